FILE: hw/rtl/gha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared codes, field widths and control types of the handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int INDEX_W  = 12;   // handle_index / result_index
    localparam int HGEN_W   = 8;    // handle_gen / result_gen
    localparam int THRESH_W = 12;   // reuse_threshold
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd1024;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_ALIVE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gha_gen_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_gen_mem
// Generation table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gha_gen_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/gha_free_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_free_fifo
// Free slot list: circular buffer memory with head/tail pointers and fill
// count. The head entry is read every cycle into a register.
// ----------------------------------------------------------------------------
module gha_free_fifo #(
    parameter int DEPTH = 4096,
    parameter int IDX_W = 12,
    parameter int CNT_W = 13
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gha_pkg::fifo_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]    push_data,
    output logic      [IDX_W-1:0]    head_data,
    output logic      [CNT_W-1:0]    count
);

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next  = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        head_data_reg <= mem[head_reg];
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> count_reg != CNT_W'(DEPTH))
        else $error("push into full free list");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> count_reg != '0)
        else $error("pop from empty free list");
    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.pop))
        else $error("push and pop in one cycle");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/generational_handle_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out (index, generation) handles, retires them and answers liveness
// queries. Generations and the free list live in synchronous memories.
//
//   channel   signals                                       flow
//   command   start, busy, operation, handle_index,         start && !busy
//             handle_gen
//   result    done, result_index, result_gen, is_alive,     one-cycle strobe
//             status
//   config    cfg_valid, cfg_ready, cfg_data                valid && ready
//
// Destroy, alive and fresh create: memory read, then decide and write back.
// Create that reuses a freed slot adds a reuse state: the free list head
// read comes before the generation read of that slot.
// The result strobe is registered from the state that ends the command;
// busy is already low then, so the next command may be taken in that cycle.
// Reset needs no clearing pass; memory read data is used only where written.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
    parameter int MAX_SLOTS = 4096,
    parameter int GEN_BITS  = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [gha_pkg::OP_W-1:0]        operation,
    input  wire logic [gha_pkg::INDEX_W-1:0]     handle_index,
    input  wire logic [gha_pkg::HGEN_W-1:0]      handle_gen,
    output logic                                 done,
    output logic      [gha_pkg::INDEX_W-1:0]     result_index,
    output logic      [gha_pkg::HGEN_W-1:0]      result_gen,
    output logic                                 is_alive,
    output logic      [gha_pkg::STATUS_W-1:0]    status,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gha_pkg::THRESH_W-1:0]    cfg_data
);

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int WIDE_W = CNT_W + gha_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_REUSE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [gha_pkg::OP_W-1:0]     op_reg, op_next;
    logic [gha_pkg::INDEX_W-1:0]  idx_reg, idx_next;
    logic [gha_pkg::HGEN_W-1:0]   hgen_reg, hgen_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic [CNT_W-1:0]             alloc_reg, alloc_next;
    logic [gha_pkg::THRESH_W-1:0] thresh_reg;
    logic                         done_reg, done_next;
    logic [gha_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [gha_pkg::HGEN_W-1:0]   res_gen_reg, res_gen_next;
    logic                         res_alive_reg, res_alive_next;
    logic [gha_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                gen_we;
    logic [IDX_W-1:0]    gen_waddr;
    logic [GEN_BITS-1:0] gen_wdata;
    logic [IDX_W-1:0]    gen_raddr;
    logic [GEN_BITS-1:0] gen_rd;

    gha_pkg::fifo_ctrl_t fifo_ctrl;
    logic [IDX_W-1:0]    fifo_head;
    logic [CNT_W-1:0]    free_count;

    logic live;

    gha_gen_mem #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (GEN_BITS)
    ) u_gen_mem (
        .clk     (clk),
        .we      (gen_we),
        .waddr   (gen_waddr),
        .wdata   (gen_wdata),
        .raddr   (gen_raddr),
        .rd_data (gen_rd)
    );

    gha_free_fifo #(
        .DEPTH (MAX_SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_free_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_data (IDX_W'(idx_reg)),
        .head_data (fifo_head),
        .count     (free_count)
    );

    // In the decide cycle the read port fetches the generation of the free
    // list head, needed only when the create reuses that slot.
    assign gen_raddr = (state_reg == S_LOOK) ? fifo_head : IDX_W'(handle_index);

    assign live = (WIDE_W'(idx_reg) < WIDE_W'(alloc_reg))
               && (gen_rd == GEN_BITS'(hgen_reg));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        hgen_next       = hgen_reg;
        slot_next       = slot_reg;
        alloc_next      = alloc_reg;
        done_next       = 1'b0;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        res_alive_next  = res_alive_reg;
        res_status_next = res_status_reg;
        gen_we          = 1'b0;
        gen_waddr       = IDX_W'(idx_reg);
        gen_wdata       = gen_rd + 1'b1;
        fifo_ctrl       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    idx_next   = handle_index;
                    hgen_next  = handle_gen;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                res_index_next  = idx_reg;
                res_gen_next    = hgen_reg;
                res_alive_next  = 1'b0;
                res_status_next = gha_pkg::ST_OK;
                unique case (op_reg)
                    gha_pkg::OP_CREATE:
                    begin
                        priority if (WIDE_W'(free_count) > WIDE_W'(thresh_reg))
                        begin
                            fifo_ctrl.pop = 1'b1;
                            slot_next     = fifo_head;
                            done_next     = 1'b0;
                            state_next    = S_REUSE;
                        end
                        else if (alloc_reg < CNT_W'(MAX_SLOTS))
                        begin
                            gen_we         = 1'b1;
                            gen_waddr      = IDX_W'(alloc_reg);
                            gen_wdata      = '0;
                            alloc_next     = alloc_reg + 1'b1;
                            res_index_next = gha_pkg::INDEX_W'(alloc_reg);
                            res_gen_next   = '0;
                        end
                        else
                        begin
                            res_index_next  = '0;
                            res_gen_next    = '0;
                            res_status_next = gha_pkg::ST_FULL;
                        end
                    end
                    gha_pkg::OP_DESTROY:
                    begin
                        res_alive_next = live;
                        if (!live || free_count == CNT_W'(MAX_SLOTS))
                        begin
                            res_status_next = gha_pkg::ST_DEAD;
                        end
                        else
                        begin
                            gen_we         = 1'b1;
                            fifo_ctrl.push = 1'b1;
                        end
                    end
                    gha_pkg::OP_ALIVE:
                    begin
                        res_alive_next = live;
                    end
                    default:
                    begin
                        res_alive_next = 1'b0;
                    end
                endcase
            end
            S_REUSE:
            begin
                res_index_next  = gha_pkg::INDEX_W'(slot_reg);
                res_gen_next    = gha_pkg::HGEN_W'(gen_rd);
                res_alive_next  = 1'b0;
                res_status_next = gha_pkg::ST_OK;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            alloc_reg  <= '0;
            done_reg   <= 1'b0;
            thresh_reg <= gha_pkg::THRESH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        hgen_reg       <= hgen_next;
        slot_reg       <= slot_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        res_alive_reg  <= res_alive_next;
        res_status_reg <= res_status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign result_index = res_index_reg;
    assign result_gen   = res_gen_reg;
    assign is_alive     = res_alive_reg;
    assign status       = res_status_reg;

`ifndef NO_ASSERTIONS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result strobe without a command in flight");
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= CNT_W'(MAX_SLOTS))
        else $error("allocated count beyond table size");
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_status_reg == gha_pkg::ST_FULL)
            |-> alloc_reg == CNT_W'(MAX_SLOTS))
        else $error("full status with fresh slots left");
    a_reuse_from_look: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REUSE |-> $past(state_reg) == S_LOOK)
        else $error("reuse cycle not preceded by decide cycle");
`endif

endmodule
`default_nettype wire
